/* rtl/fifo_with_negative_purge_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the queue with negative-value purge
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_NEGATIVE_PURGE_MACROS_SVH
`define FIFO_WITH_NEGATIVE_PURGE_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define FWNP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwnp assertion failed");
// antecedent implies consequent in the next cycle
`define FWNP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwnp assertion failed");
`else
`define FWNP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FWNP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/fwnp_pkg.sv */
// ----------------------------------------------------------------------------
// fwnp_pkg
// Codes and controller/datapath interface types for the purge queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwnp_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_SHOW  = 2'd2;
  localparam logic [1:0] ACT_PURGE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       push_wr;
    logic       pop_rd;
    logic       pop_done;
    logic       walk_start;
    logic       walk_rd;
    logic       walk_step;
    logic       keep_wr;
    logic       purge_commit;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_use_rd;
    logic       out_last;
  } fwnp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
    logic rd_neg;
    logic out_free;
  } fwnp_stat_t;

endpackage

/* rtl/fifo_with_negative_purge.sv */
// ----------------------------------------------------------------------------
// fifo_with_negative_purge
// Bounded queue of signed 32-bit values with pop, show and negative purge.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tuser = action, s_tdata = value
// m_*      out  m_tvalid/m_tready   m_tuser = status, m_tdata = data, m_tlast = last
//
// Push is handled on acceptance; pop first issues a registered read of the ring
// memory. Show reads each stored entry (S_SHOW_RD) before outputting it
// (S_SHOW_OUT); purge reads and rewrites each entry, then commits in S_PURGE_DONE.
// Input is held off while a pop or walk runs or the output register is stalled.
// Synchronous reset clears pointers and count; ring contents need no clearing.
`timescale 1ns / 1ps

module fifo_with_negative_purge
  import fwnp_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // [31:0] value
  input  logic [1:0]        s_tuser,  // [1:0] action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,  // [31:0] data
  output logic [1:0]        m_tuser,  // [1:0] status
  output logic              m_tlast
);

  fwnp_cmd_t  cmd;
  fwnp_stat_t stat;

  fwnp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fwnp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_value (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* rtl/fwnp_ctrl.sv */
// ----------------------------------------------------------------------------
// fwnp_ctrl
// Sequencer for push, pop, show walk and purge compaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwnp_ctrl
  import fwnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  input  fwnp_stat_t stat,
  output fwnp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_POP_WAIT   = 3'd1;
  localparam logic [2:0] S_SHOW_RD    = 3'd2;
  localparam logic [2:0] S_SHOW_OUT   = 3'd3;
  localparam logic [2:0] S_PURGE_RD   = 3'd4;
  localparam logic [2:0] S_PURGE_WR   = 3'd5;
  localparam logic [2:0] S_PURGE_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_PUSH: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.out_status = ST_OK;
                cmd.push_wr    = 1'b1;
              end
            end
            ACT_POP: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
                cmd.out_last   = 1'b1;
              end else begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_WAIT;
              end
            end
            ACT_SHOW: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
                cmd.out_last   = 1'b1;
              end else begin
                cmd.walk_start = 1'b1;
                state_next     = S_SHOW_RD;
              end
            end
            ACT_PURGE: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_OK;
                cmd.out_last   = 1'b1;
              end else begin
                cmd.walk_start = 1'b1;
                state_next     = S_PURGE_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP_WAIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_use_rd = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.pop_done   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SHOW_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_SHOW_OUT;
      end
      S_SHOW_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_OK;
          cmd.out_use_rd = 1'b1;
          cmd.out_last   = stat.walk_last;
          cmd.walk_step  = 1'b1;
          state_next     = stat.walk_last ? S_IDLE : S_SHOW_RD;
        end
      end
      S_PURGE_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_PURGE_WR;
      end
      S_PURGE_WR: begin
        // keep only non-negative entries, packed behind the write pointer
        cmd.keep_wr   = !stat.rd_neg;
        cmd.walk_step = 1'b1;
        state_next    = stat.walk_last ? S_PURGE_DONE : S_PURGE_RD;
      end
      S_PURGE_DONE: begin
        if (stat.out_free) begin
          cmd.purge_commit = 1'b1;
          cmd.out_load     = 1'b1;
          cmd.out_status   = ST_OK;
          cmd.out_last     = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/fwnp_datapath.sv */
// ----------------------------------------------------------------------------
// fwnp_datapath
// Ring storage, pointers, walk counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_with_negative_purge_macros.svh"

module fwnp_datapath
  import fwnp_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  fwnp_cmd_t         cmd,
  output fwnp_stat_t        stat,
  input  logic [DATA_W-1:0] in_value,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [DATA_W-1:0] m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] walk;
  logic [IDX_W-1:0] wr_ptr;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] kept;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_MAX) ? '0 : p + 1'b1;
  endfunction

  assign rd_en   = cmd.pop_rd || cmd.walk_rd;
  assign rd_addr = cmd.pop_rd ? head : walk;
  assign wr_en   = cmd.push_wr || cmd.keep_wr;
  assign wr_addr = cmd.push_wr ? tail : wr_ptr;
  assign wr_data = cmd.push_wr ? in_value : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push_wr) begin
        tail  <= wrap_inc(tail);
        count <= count + 1'b1;
      end
      if (cmd.pop_done) begin
        head  <= wrap_inc(head);
        count <= count - 1'b1;
      end
      if (cmd.purge_commit) begin
        tail  <= wr_ptr;
        count <= kept;
      end
    end
  end

  // walk state: read pointer, compaction pointer, entries left, entries kept
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      walk   <= head;
      wr_ptr <= head;
      remain <= count;
      kept   <= '0;
    end else begin
      if (cmd.walk_step) begin
        walk   <= wrap_inc(walk);
        remain <= remain - 1'b1;
      end
      if (cmd.keep_wr) begin
        wr_ptr <= wrap_inc(wr_ptr);
        kept   <= kept + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= cmd.out_status;
      m_tdata <= cmd.out_use_rd ? rd_data : '0;
      m_tlast <= cmd.out_last;
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_MAX);
  assign stat.walk_last = (remain == CNT_W'(1));
  assign stat.rd_neg    = rd_data[DATA_W-1];
  assign stat.out_free  = !m_tvalid || m_tready;

  `FWNP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_MAX)
  `FWNP_ASSERT_IMP(a_push_not_full, clk, rst, cmd.push_wr, !stat.full)
  `FWNP_ASSERT_IMP(a_empty_ptrs, clk, rst, stat.empty || stat.full, head == tail)
  `FWNP_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, stat.out_free)
  `FWNP_ASSERT_NXT(a_commit_bound, clk, rst, cmd.purge_commit, count <= CNT_MAX)

endmodule
